// File: rtl/lgs_pkg.sv
// lgs_pkg: shared types and codes for the line gaussian smoothing block
// used by lgs_mac and line_gaussian_smoothing; no dependencies
package lgs_pkg;

    // input transaction kinds, carried in tuser
    localparam logic OP_COEF  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // sequencer states of the window control
    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_CLR
    } t_state;

    // control carried alongside each result through the pipeline
    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

endpackage

// File: rtl/lgs_mac.sv
// lgs_mac: per-tap multiply, grouped adder tree, floor and saturate
// three register stages with a common enable; depends on lgs_pkg
module lgs_mac #(
    parameter int MAX_TAPS   = 31,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  lgs_pkg::t_tag         i_tag,
    input  logic [4:0]            i_span,
    input  logic [15:0]           i_coef [MAX_TAPS],
    input  logic [PIXEL_BITS-1:0] i_win  [MAX_TAPS],
    output lgs_pkg::t_tag         o_tag,
    output logic [15:0]           o_smoothed
);

    localparam int IW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PW     = PIXEL_BITS + 16;
    localparam int SUM_W  = PW + $clog2(MAX_TAPS + 1);
    localparam int GROUPS = (MAX_TAPS + 7) / 8;

    logic [PIXEL_BITS-1:0] w_opd  [MAX_TAPS];
    logic [PW-1:0]         r_prod [MAX_TAPS];
    logic [SUM_W-1:0]      n_grp  [GROUPS];
    logic [SUM_W-1:0]      r_grp  [GROUPS];
    logic [SUM_W-1:0]      w_tot;
    logic [SUM_W-1:0]      w_shf;
    logic [15:0]           n_out;
    lgs_pkg::t_tag         r_tag1;
    lgs_pkg::t_tag         r_tag2;
    lgs_pkg::t_tag         r_tag3;
    logic [15:0]           r_out;

    // lane k pairs coefficient k with window entry span-k
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_lane
        logic       w_act;
        logic [5:0] w_dif;
        assign w_act    = {1'b0, i_span} >= 6'(k);
        assign w_dif    = {1'b0, i_span} - 6'(k);
        assign w_opd[k] = w_act ? i_win[w_dif[IW-1:0]] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_prod[k] <= PW'(i_coef[k]) * PW'(w_opd[k]);
            end
        end
    end

    // partial sums over groups of eight lanes
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp[g] = '0;
            for (int e = 0; e < 8; e++) begin
                if (g * 8 + e < MAX_TAPS) begin
                    n_grp[g] = n_grp[g] + SUM_W'(r_prod[g * 8 + e]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < GROUPS; g++) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    // final sum, floor by dropping the fraction, saturate
    always_comb begin
        w_tot = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_tot = w_tot + r_grp[g];
        end
        w_shf = w_tot >> 16;
        if (|w_shf[SUM_W-1:PIXEL_BITS]) begin
            n_out = 16'({PIXEL_BITS{1'b1}});
        end else begin
            n_out = 16'(w_shf[PIXEL_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else if (i_en) begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_tag      = r_tag3;
    assign o_smoothed = r_out;

endmodule

// File: rtl/line_gaussian_smoothing.sv
// line_gaussian_smoothing: one horizontal pass of a separable gaussian filter
// top level with window shift line, end-of-line sequencer and coefficient table;
// depends on lgs_pkg and lgs_mac
//
//   channel  | dir | handshake                 | payload
//   ---------+-----+---------------------------+--------------------------------------
//   s stream | in  | i_s_tvalid / o_s_tready   | tdata, tuser = op, tlast = last_in_line
//   m stream | out | o_m_tvalid / i_m_tready   | tdata = smoothed, tlast = last_out
//   cfg      | in  | i_cfg_we                  | i_cfg_wdata = tap_half
//
// one transaction per cycle unless stalled or flushing; a result trails its pixel
// by the window register, product stage, group sum stage and output register
// at the end of a line the input pauses while the pending results are flushed;
// the flush shifts in h zeros, h being the clamped half width
// synchronous active-low reset clears coefficients, window and line counter;
// tap_half resets to 2
// a stalled output register freezes the whole pipeline and the input side
module line_gaussian_smoothing #(
    parameter int MAX_TAPS   = 31,
    parameter int PIXEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [4:0] coef_index, [20:5] coef_value, [36:21] pixel
    input  logic        i_s_tuser,   // [0] op
    input  logic        i_s_tlast,   // last_in_line
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] smoothed
    output logic        o_m_tlast    // last_out
);

    localparam int H_LIM = (MAX_TAPS - 1) / 2;
    localparam int H_CAP = (H_LIM > 15) ? 15 : H_LIM;

    // payload fields
    logic [4:0]            w_cidx;
    logic [15:0]           w_cval;
    logic [PIXEL_BITS-1:0] w_pix_val;

    // registers
    logic [3:0]            r_tap_half;
    logic [15:0]           r_coef [MAX_TAPS];
    logic [PIXEL_BITS-1:0] r_win  [MAX_TAPS];
    logic [PIXEL_BITS-1:0] n_win  [MAX_TAPS];
    logic [15:0]           r_pos;
    logic [15:0]           n_pos;
    logic [3:0]            r_pend;
    logic [3:0]            n_pend;
    logic [3:0]            r_skip;
    logic [3:0]            n_skip;
    lgs_pkg::t_state       r_state;
    lgs_pkg::t_state       n_state;
    lgs_pkg::t_tag         r_s0;
    lgs_pkg::t_tag         n_s0;

    // control
    logic                  w_h_big;
    logic [3:0]            w_h;
    logic                  w_adv;
    logic                  w_acc;
    logic                  w_pix;
    logic                  w_cwr;
    logic                  w_reach;
    logic                  w_flush_step;
    logic                  w_clr_step;
    lgs_pkg::t_tag         w_mac_tag;

    assign w_cidx    = i_s_tdata[4:0];
    assign w_cval    = i_s_tdata[20:5];
    assign w_pix_val = i_s_tdata[21 +: PIXEL_BITS];

    // half width clamped to what the tap storage holds
    assign w_h_big = 32'(r_tap_half) > H_CAP;
    assign w_h     = w_h_big ? 4'(H_CAP) : r_tap_half;

    // whole pipeline moves when the output register is free or being taken
    assign w_adv = !w_mac_tag.vld || i_m_tready;

    assign w_acc   = i_s_tvalid && o_s_tready;
    assign w_pix   = w_acc && (i_s_tuser == lgs_pkg::OP_PIXEL);
    assign w_cwr   = w_acc && (i_s_tuser == lgs_pkg::OP_COEF);
    // enough pixels seen in this line for the centered output to exist
    assign w_reach = r_pos >= 16'(w_h);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_half <= 4'd2;
        end else if (i_cfg_we) begin
            r_tap_half <= i_cfg_wdata;
        end
    end

    // coefficient table; indexes at or beyond the depth fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_TAPS; j++) begin
                r_coef[j] <= '0;
            end
        end else if (w_cwr) begin
            for (int j = 0; j < MAX_TAPS; j++) begin
                if ({1'b0, w_cidx} == 6'(j)) begin
                    r_coef[j] <= w_cval;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            lgs_pkg::ST_RUN, lgs_pkg::ST_CLR: begin
                if (w_pix && i_s_tlast) begin
                    n_state = (w_h == 4'd0) ? lgs_pkg::ST_CLR : lgs_pkg::ST_FLUSH;
                end else if (w_adv) begin
                    n_state = lgs_pkg::ST_RUN;
                end
            end
            lgs_pkg::ST_FLUSH: begin
                if (w_adv && r_skip == 4'd0 && r_pend == 4'd1) begin
                    n_state = lgs_pkg::ST_CLR;
                end
            end
            default: n_state = lgs_pkg::ST_RUN;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready   = 1'b0;
        w_flush_step = 1'b0;
        w_clr_step   = 1'b0;
        unique case (r_state)
            lgs_pkg::ST_RUN:   o_s_tready = w_adv;
            lgs_pkg::ST_CLR: begin
                o_s_tready = w_adv;
                w_clr_step = w_adv;
            end
            lgs_pkg::ST_FLUSH: w_flush_step = w_adv;
            default: o_s_tready = 1'b0;
        endcase
    end

    // window, launch tag and line counters
    always_comb begin
        n_win  = r_win;
        n_s0   = r_s0;
        n_pos  = r_pos;
        n_pend = r_pend;
        n_skip = r_skip;
        if (w_pix) begin
            // a cleared window is the base for the first pixel after a line end
            n_win[0] = w_pix_val;
            for (int j = 1; j < MAX_TAPS; j++) begin
                n_win[j] = w_clr_step ? '0 : r_win[j-1];
            end
            n_s0.vld  = w_reach;
            n_s0.last = i_s_tlast && (w_h == 4'd0);
            if (i_s_tlast) begin
                n_pos = '0;
                if (w_reach) begin
                    n_pend = w_h;
                    n_skip = '0;
                end else begin
                    // short line: leading zero shifts before the first flush output
                    n_pend = r_pos[3:0] + 4'd1;
                    n_skip = w_h - r_pos[3:0] - 4'd1;
                end
            end else if (r_pos != 16'hFFFF) begin
                n_pos = r_pos + 16'd1;
            end
        end else if (w_flush_step) begin
            // flush: shift a zero each cycle the pipeline advances, emit once the lead-in is done
            n_win[0] = '0;
            for (int j = 1; j < MAX_TAPS; j++) begin
                n_win[j] = r_win[j-1];
            end
            if (r_skip != 4'd0) begin
                n_skip   = r_skip - 4'd1;
                n_s0.vld = 1'b0;
            end else begin
                n_pend    = r_pend - 4'd1;
                n_s0.vld  = 1'b1;
                n_s0.last = (r_pend == 4'd1);
            end
        end else if (w_adv) begin
            n_s0.vld = 1'b0;
            if (w_clr_step) begin
                for (int j = 0; j < MAX_TAPS; j++) begin
                    n_win[j] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgs_pkg::ST_RUN;
            r_s0    <= '0;
            r_pos   <= '0;
            r_pend  <= '0;
            r_skip  <= '0;
            for (int j = 0; j < MAX_TAPS; j++) begin
                r_win[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_s0    <= n_s0;
            r_pos   <= n_pos;
            r_pend  <= n_pend;
            r_skip  <= n_skip;
            r_win   <= n_win;
        end
    end

    lgs_mac #(
        .MAX_TAPS   (MAX_TAPS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_tag      (r_s0),
        .i_span     ({w_h, 1'b0}),
        .i_coef     (r_coef),
        .i_win      (r_win),
        .o_tag      (w_mac_tag),
        .o_smoothed (o_m_tdata)
    );

    assign o_m_tvalid = w_mac_tag.vld;
    assign o_m_tlast  = w_mac_tag.last;

    // no input taken while the line end is being flushed
    a_no_acc_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgs_pkg::ST_FLUSH) |-> !o_s_tready)
        else $error("input accepted during flush");

    // flush always has at least one result left to give
    a_pend_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgs_pkg::ST_FLUSH) |-> (r_pend != 4'd0))
        else $error("flush with nothing pending");

    // lead-in count only lives inside a flush
    a_skip_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != 4'd0) |-> (r_state == lgs_pkg::ST_FLUSH))
        else $error("lead-in count outside flush");

    // a last pixel with a nonzero half width starts a flush
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pix && i_s_tlast && w_h != 4'd0) |=> (r_state == lgs_pkg::ST_FLUSH))
        else $error("line end did not start flush");

    // the window is cleared before the next line when no pixel comes in
    a_clr_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_clr_step && !w_pix) |=> (r_win[0] == '0))
        else $error("window not cleared after line end");

endmodule
